FILE: hdl/tad_pkg.sv
// ----------------------------------------------------------------------------
// tad_pkg
// Shared types, constants and helpers of the triangular arbitrage detector.
// ----------------------------------------------------------------------------
package tad_pkg;

    localparam int CURRENCY_COUNT = 8;
    localparam int CELLS          = CURRENCY_COUNT * CURRENCY_COUNT;
    localparam int IDX_W          = $clog2(CURRENCY_COUNT);
    localparam int ADDR_W         = $clog2(CELLS);
    localparam int PCNT_W         = $clog2(CURRENCY_COUNT + 1);
    localparam int MAX_OPPS       = 6;
    localparam int FOUND_W        = $clog2(MAX_OPPS + 1);
    localparam int DVD_W          = 49;
    localparam int DIV_CNT_W      = $clog2(DVD_W);
    localparam int CODE_COUNT     = 8;

    localparam logic [31:0] THRESHOLD_RESET = 32'd16780570;
    localparam logic [31:0] U32_MAX         = 32'hFFFF_FFFF;

    // ceil(2^56 / 3125): mid = sum * 2^18 / 3125 = (sum * MID_RECIP) >> 38
    localparam logic [63:0] MID_RECIP = 64'd23058430092137;
    // smallest price sum whose mid no longer fits 32 bits
    localparam logic [32:0] MID_SAT   = 33'd51200000;

    localparam logic [1:0] KIND_OPP = 2'd0;
    localparam logic [1:0] KIND_SUM = 2'd1;
    localparam logic [1:0] KIND_REJ = 2'd2;

    localparam logic [23:0] CODE_LIST [CODE_COUNT] = '{
        24'h555344, 24'h455552, 24'h474250, 24'h4A5059,
        24'h434846, 24'h415544, 24'h434144, 24'h4E5A44
    };

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic mid_lo;
        logic mid_hi;
        logic div_start;
        logic latch_mid;
        logic latch_inv;
        logic wr_mid;
        logic wr_inv;
        logic piv_clear;
        logic piv_inc;
        logic rd_first;
        logic rd_second;
        logic cap_r1;
        logic mul_r12;
        logic mul_lo;
        logic mul_hi;
        logic add;
        logic emit_opp;
        logic emit_sum;
        logic emit_rej;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic div_done;
        logic mid_zero;
        logic piv_end;
        logic piv_skip;
        logic hit;
        logic out_free;
    } sts_t;

    function automatic lookup_t lookup_code(input logic [23:0] code);
        lookup_t r;
        r.ok  = 1'b0;
        r.idx = '0;
        for (int i = CODE_COUNT - 1; i >= 0; i--)
        begin
            if (CODE_LIST[i] == code && i < CURRENCY_COUNT)
            begin
                r.ok  = 1'b1;
                r.idx = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/tad_ram.sv
// ----------------------------------------------------------------------------
// tad_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/tad_div.sv
// ----------------------------------------------------------------------------
// tad_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module tad_div import tad_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [31:0]      divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     work_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          dvs_reg;
    logic [32:0]          rem_sh;
    logic                 ge;
    logic [32:0]          rem_sub;

    assign rem_sh  = {rem_reg, work_reg[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[DVD_W-2:0], ge};
            rem_reg  <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign done     = done_reg;
    assign quotient = (|work_reg[DVD_W-1:32]) ? U32_MAX : work_reg[31:0];

endmodule

FILE: hdl/tad_datapath.sv
// ----------------------------------------------------------------------------
// tad_datapath
// Tick capture, divider, rate table, path product and result register.
// ----------------------------------------------------------------------------
module tad_datapath import tad_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    input  logic [23:0] base_code,
    input  logic [23:0] quote_code,
    input  logic [31:0] bid_px,
    input  logic [31:0] ask_px,
    input  logic [63:0] event_time,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [1:0]  kind,
    output logic [4:0]  base_index,
    output logic [4:0]  pivot_index,
    output logic [4:0]  quote_index,
    output logic [31:0] path_rate,
    output logic [31:0] opportunity_id,
    output logic [4:0]  found_count,
    output logic [63:0] stamp,
    output logic        last
);

    lookup_t lb;
    lookup_t lq;

    logic [31:0]        thr_reg;
    logic [IDX_W-1:0]   b_reg;
    logic [IDX_W-1:0]   q_reg;
    logic               bad_reg;
    logic [32:0]        sum_reg;
    logic [63:0]        time_reg;
    logic [31:0]        mid_reg;
    logic [31:0]        inv_reg;
    logic [PCNT_W-1:0]  p_reg;
    logic [FOUND_W-1:0] found_reg;
    logic [31:0]        opp_cnt_reg;
    logic [CELLS-1:0]   valid_reg;
    logic [31:0]        r1_reg;
    logic [63:0]        a_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        carry_reg;
    logic [31:0]        rate_reg;
    logic               out_valid_reg;

    logic [DVD_W-1:0]   div_dvd;
    logic [31:0]        div_dvs;
    logic               div_done;
    logic [31:0]        div_q;

    logic [IDX_W-1:0]   p_idx;
    logic [ADDR_W-1:0]  addr_bp;
    logic [ADDR_W-1:0]  addr_pq;
    logic [ADDR_W-1:0]  addr_bq;
    logic [ADDR_W-1:0]  addr_qb;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [31:0]        ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [31:0]        ram_rdata;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [64:0]        path_sum;
    logic               emit;
    logic               out_take;

    assign lb = lookup_code(base_code);
    assign lq = lookup_code(quote_code);

    assign p_idx   = p_reg[IDX_W-1:0];
    assign addr_bp = ADDR_W'(b_reg) * ADDR_W'(CURRENCY_COUNT) + ADDR_W'(p_idx);
    assign addr_pq = ADDR_W'(p_idx) * ADDR_W'(CURRENCY_COUNT) + ADDR_W'(q_reg);
    assign addr_bq = ADDR_W'(b_reg) * ADDR_W'(CURRENCY_COUNT) + ADDR_W'(q_reg);
    assign addr_qb = ADDR_W'(q_reg) * ADDR_W'(CURRENCY_COUNT) + ADDR_W'(b_reg);

    // reciprocal 2^48 / mid
    assign div_dvd = DVD_W'(1) << 48;
    assign div_dvs = mid_reg;

    tad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign ram_we    = cmd.wr_mid | cmd.wr_inv;
    assign ram_waddr = cmd.wr_inv ? addr_qb : addr_bq;
    assign ram_wdata = cmd.wr_inv ? inv_reg : mid_reg;
    assign ram_raddr = cmd.rd_second ? addr_pq : addr_bp;

    tad_ram #(
        .WIDTH (32),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one shared multiplier: sum times the two halves of the 1/3125 reciprocal,
    // then r1*r2, then low and high halves times r3
    always_comb
    begin
        mul_a = r1_reg;
        mul_b = ram_rdata;
        if (cmd.mid_lo)
        begin
            mul_a = 32'(sum_reg[25:0]);
            mul_b = MID_RECIP[31:0];
        end
        else if (cmd.mid_hi)
        begin
            mul_a = 32'(sum_reg[25:0]);
            mul_b = MID_RECIP[63:32];
        end
        else if (cmd.mul_lo)
        begin
            mul_a = a_reg[31:0];
            mul_b = inv_reg;
        end
        else if (cmd.mul_hi)
        begin
            mul_a = a_reg[63:32];
            mul_b = inv_reg;
        end
    end

    assign mul_p    = 64'(mul_a) * 64'(mul_b);
    assign path_sum = 65'(prod_reg) + 65'(carry_reg);

    assign emit     = cmd.emit_opp | cmd.emit_sum | cmd.emit_rej;
    assign out_take = out_valid_reg & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            opp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CURRENCY_COUNT; i++)
            begin
                for (int j = 0; j < CURRENCY_COUNT; j++)
                begin
                    valid_reg[i*CURRENCY_COUNT+j] <= (i == j);
                end
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (cmd.wr_mid)
            begin
                valid_reg[addr_bq] <= 1'b1;
            end
            if (cmd.wr_inv)
            begin
                valid_reg[addr_qb] <= 1'b1;
            end
            if (cmd.emit_opp)
            begin
                opp_cnt_reg <= opp_cnt_reg + 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            b_reg    <= lb.idx;
            q_reg    <= lq.idx;
            bad_reg  <= ~lb.ok | ~lq.ok | (lb.idx == lq.idx);
            sum_reg  <= 33'(bid_px) + 33'(ask_px);
            time_reg <= event_time;
        end
        // exact below MID_SAT, where only the low 26 bits of the sum are set
        if (cmd.latch_mid)
        begin
            mid_reg <= (sum_reg >= MID_SAT) ? U32_MAX : path_sum[37:6];
        end
        if (cmd.latch_inv)
        begin
            inv_reg <= div_q;
        end
        if (cmd.piv_clear)
        begin
            p_reg     <= '0;
            found_reg <= '0;
        end
        else
        begin
            if (cmd.piv_inc)
            begin
                p_reg <= p_reg + 1'b1;
            end
            if (cmd.emit_opp)
            begin
                found_reg <= found_reg + 1'b1;
            end
        end
        if (cmd.cap_r1)
        begin
            r1_reg <= ram_rdata;
        end
        if (cmd.mul_r12)
        begin
            a_reg <= mul_p;
        end
        if (cmd.mul_lo | cmd.mid_lo)
        begin
            prod_reg <= mul_p;
        end
        else if (cmd.mul_hi | cmd.mid_hi)
        begin
            prod_reg  <= mul_p;
            carry_reg <= prod_reg[63:32];
        end
        if (cmd.add)
        begin
            rate_reg <= (|path_sum[64:48]) ? U32_MAX : path_sum[47:16];
        end
        if (emit)
        begin
            kind           <= cmd.emit_opp ? KIND_OPP : (cmd.emit_sum ? KIND_SUM : KIND_REJ);
            base_index     <= cmd.emit_rej ? 5'd0 : 5'(b_reg);
            quote_index    <= cmd.emit_rej ? 5'd0 : 5'(q_reg);
            pivot_index    <= cmd.emit_opp ? 5'(p_idx) : 5'd0;
            path_rate      <= cmd.emit_opp ? rate_reg : 32'd0;
            opportunity_id <= cmd.emit_opp ? opp_cnt_reg : 32'd0;
            found_count    <= cmd.emit_sum ? 5'(found_reg) : 5'd0;
            stamp          <= time_reg;
            last           <= ~cmd.emit_opp;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.bad      = bad_reg;
    assign sts.div_done = div_done;
    assign sts.mid_zero = (mid_reg == 32'd0);
    assign sts.piv_end  = (p_reg == PCNT_W'(CURRENCY_COUNT))
                        | (found_reg == FOUND_W'(MAX_OPPS));
    assign sts.piv_skip = (p_idx == b_reg) | (p_idx == q_reg)
                        | ~valid_reg[addr_bp] | ~valid_reg[addr_pq];
    assign sts.hit      = rate_reg > thr_reg;
    assign sts.out_free = ~out_valid_reg | ~out_stall;

endmodule

FILE: hdl/tad_ctrl.sv
// ----------------------------------------------------------------------------
// tad_ctrl
// Sequencer: check, mid price, reciprocal, table update, pivot walk, result beats.
// ----------------------------------------------------------------------------
module tad_ctrl import tad_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [17:0] {
        ST_IDLE  = 18'b00_0000_0000_0000_0001,
        ST_CHECK = 18'b00_0000_0000_0000_0010,
        ST_MLO   = 18'b00_0000_0000_0000_0100,
        ST_MHI   = 18'b00_0000_0000_0000_1000,
        ST_MID   = 18'b00_0000_0000_0001_0000,
        ST_ZCHK  = 18'b00_0000_0000_0010_0000,
        ST_DIV   = 18'b00_0000_0000_0100_0000,
        ST_WR1   = 18'b00_0000_0000_1000_0000,
        ST_WR2   = 18'b00_0000_0001_0000_0000,
        ST_PIV   = 18'b00_0000_0010_0000_0000,
        ST_RD2   = 18'b00_0000_0100_0000_0000,
        ST_MUL1  = 18'b00_0000_1000_0000_0000,
        ST_MUL2  = 18'b00_0001_0000_0000_0000,
        ST_MUL3  = 18'b00_0010_0000_0000_0000,
        ST_ADD   = 18'b00_0100_0000_0000_0000,
        ST_CMP   = 18'b00_1000_0000_0000_0000,
        ST_SUM   = 18'b01_0000_0000_0000_0000,
        ST_REJ   = 18'b10_0000_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.bad)
                begin
                    state_next = ST_REJ;
                end
                else
                begin
                    state_next = ST_MLO;
                end
            end
            ST_MLO:
            begin
                cmd.mid_lo = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.mid_hi = 1'b1;
                state_next = ST_MID;
            end
            ST_MID:
            begin
                cmd.latch_mid = 1'b1;
                state_next    = ST_ZCHK;
            end
            ST_ZCHK:
            begin
                if (sts.mid_zero)
                begin
                    state_next = ST_REJ;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.latch_inv = 1'b1;
                    state_next    = ST_WR1;
                end
            end
            ST_WR1:
            begin
                cmd.wr_mid = 1'b1;
                state_next = ST_WR2;
            end
            ST_WR2:
            begin
                cmd.wr_inv    = 1'b1;
                cmd.piv_clear = 1'b1;
                state_next    = ST_PIV;
            end
            ST_PIV:
            begin
                if (sts.piv_end)
                begin
                    state_next = ST_SUM;
                end
                else if (sts.piv_skip)
                begin
                    cmd.piv_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = ST_RD2;
                end
            end
            ST_RD2:
            begin
                cmd.rd_second = 1'b1;
                cmd.cap_r1    = 1'b1;
                state_next    = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_r12 = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!sts.hit)
                begin
                    cmd.piv_inc = 1'b1;
                    state_next  = ST_PIV;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_opp = 1'b1;
                    cmd.piv_inc  = 1'b1;
                    state_next   = ST_PIV;
                end
            end
            ST_SUM:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sum = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_REJ:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_rej = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

FILE: hdl/triangular_arbitrage_detector.sv
// ----------------------------------------------------------------------------
// triangular_arbitrage_detector
// sequence: a bad or equal code is rejected after the check, a zero mid price
// after the mid price step; a good tick computes the mid price, the reciprocal
// divide and the table writes, then walks the pivots, skipping some and fully
// checking the rest, closes the walk and sends the summary beat.
// flow: one tick at a time, and in_stall holds the next tick off until the
// last result beat is issued; output stalls hold the walk and the beats too.
// reset: only diagonal rate entries read as set, threshold 1.0002, counter zero.
// ----------------------------------------------------------------------------
module triangular_arbitrage_detector import tad_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] base_code,
    input  logic [23:0] quote_code,
    input  logic [31:0] bid_px,
    input  logic [31:0] ask_px,
    input  logic [63:0] event_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [4:0]  base_index,
    output logic [4:0]  pivot_index,
    output logic [4:0]  quote_index,
    output logic [31:0] path_rate,
    output logic [31:0] opportunity_id,
    output logic [4:0]  found_count,
    output logic [63:0] stamp,
    output logic        last
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tad_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .base_code      (base_code),
        .quote_code     (quote_code),
        .bid_px         (bid_px),
        .ask_px         (ask_px),
        .event_time     (event_time),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .kind           (kind),
        .base_index     (base_index),
        .pivot_index    (pivot_index),
        .quote_index    (quote_index),
        .path_rate      (path_rate),
        .opportunity_id (opportunity_id),
        .found_count    (found_count),
        .stamp          (stamp),
        .last           (last)
    );

endmodule

FILE: bench/triangular_arbitrage_detector_tb.sv
// ----------------------------------------------------------------------------
// triangular_arbitrage_detector_tb
// Drives price ticks and threshold writes into the arbitrage detector, keeps
// its own rate table and opportunity count, and checks every result beat.
// ----------------------------------------------------------------------------
module triangular_arbitrage_detector_tb import tad_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  base_index;
        logic [4:0]  pivot_index;
        logic [4:0]  quote_index;
        logic [31:0] path_rate;
        logic [31:0] opportunity_id;
        logic [4:0]  found_count;
        logic [63:0] stamp;
        logic        last;
    } finding_t;

    class arb_scoreboard;
        logic [31:0] rates [CELLS];
        bit          known [CELLS];
        logic [31:0] opp_count;
        logic [31:0] threshold;
        finding_t    pending [$];
        int          errors;

        function new();
            for (int i = 0; i < CELLS; i++)
            begin
                rates[i] = 32'd0;
                known[i] = 1'b0;
            end
            for (int i = 0; i < CURRENCY_COUNT; i++)
            begin
                rates[i * CURRENCY_COUNT + i] = 32'h0100_0000;
                known[i * CURRENCY_COUNT + i] = 1'b1;
            end
            opp_count = 32'd0;
            threshold = THRESHOLD_RESET;
            errors    = 0;
        endfunction

        function int code_index(logic [23:0] code);
            for (int i = 0; i < CODE_COUNT; i++)
                if (CODE_LIST[i] == code && i < CURRENCY_COUNT)
                    return i;
            return -1;
        endfunction

        function logic [31:0] clip32(logic [127:0] v);
            return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        function void push(logic [1:0] k, int b, int p, int q, logic [31:0] r,
                           logic [31:0] id, int cnt, logic [63:0] ts, logic l);
            finding_t f;
            f.kind = k;
            f.base_index = 5'(b);
            f.pivot_index = 5'(p);
            f.quote_index = 5'(q);
            f.path_rate = r;
            f.opportunity_id = id;
            f.found_count = 5'(cnt);
            f.stamp = ts;
            f.last = l;
            pending.push_back(f);
        endfunction

        function void note_tick(logic [23:0] bc, logic [23:0] qc, logic [31:0] bid,
                                logic [31:0] ask, logic [63:0] ts);
            int b;
            int q;
            int found;
            logic [127:0] sum;
            logic [31:0] mid;
            logic [31:0] inv;
            logic [31:0] r;
            b = code_index(bc);
            q = code_index(qc);
            found = 0;
            if (b < 0 || q < 0 || b == q)
            begin
                push(KIND_REJ, 0, 0, 0, 0, 0, 0, ts, 1'b1);
                return;
            end
            sum = 128'(bid) + 128'(ask);
            mid = clip32((sum << 23) / 128'd100000);
            if (mid == 32'd0)
            begin
                push(KIND_REJ, 0, 0, 0, 0, 0, 0, ts, 1'b1);
                return;
            end
            inv = clip32((128'd1 << 48) / 128'(mid));
            rates[b * CURRENCY_COUNT + q] = mid;
            known[b * CURRENCY_COUNT + q] = 1'b1;
            rates[q * CURRENCY_COUNT + b] = inv;
            known[q * CURRENCY_COUNT + b] = 1'b1;
            for (int p = 0; p < CURRENCY_COUNT && found < MAX_OPPS; p++)
            begin
                if (p == b || p == q)
                    continue;
                if (!known[b * CURRENCY_COUNT + p] || !known[p * CURRENCY_COUNT + q])
                    continue;
                r = clip32((128'(rates[b * CURRENCY_COUNT + p])
                            * 128'(rates[p * CURRENCY_COUNT + q]) * 128'(inv)) >> 48);
                if (r > threshold)
                begin
                    push(KIND_OPP, b, p, q, r, opp_count, 0, ts, 1'b0);
                    opp_count = opp_count + 32'd1;
                    found++;
                end
            end
            push(KIND_SUM, b, 0, q, 0, 0, found, ts, 1'b1);
        endfunction

        function void check_finding(finding_t got);
            finding_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat kind %0d", got.kind);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind)
                begin $error("kind exp %0h got %0h", exp.kind, got.kind); errors++; end
            if (got.base_index !== exp.base_index)
                begin $error("base_index exp %0h got %0h", exp.base_index,
                             got.base_index); errors++; end
            if (got.pivot_index !== exp.pivot_index)
                begin $error("pivot_index exp %0h got %0h", exp.pivot_index,
                             got.pivot_index); errors++; end
            if (got.quote_index !== exp.quote_index)
                begin $error("quote_index exp %0h got %0h", exp.quote_index,
                             got.quote_index); errors++; end
            if (got.path_rate !== exp.path_rate)
                begin $error("path_rate exp %0h got %0h", exp.path_rate,
                             got.path_rate); errors++; end
            if (got.opportunity_id !== exp.opportunity_id)
                begin $error("opportunity_id exp %0h got %0h", exp.opportunity_id,
                             got.opportunity_id); errors++; end
            if (got.found_count !== exp.found_count)
                begin $error("found_count exp %0h got %0h", exp.found_count,
                             got.found_count); errors++; end
            if (got.stamp !== exp.stamp)
                begin $error("stamp exp %0h got %0h", exp.stamp, got.stamp); errors++; end
            if (got.last !== exp.last)
                begin $error("last exp %0h got %0h", exp.last, got.last); errors++; end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [23:0] base_code;
    logic [23:0] quote_code;
    logic [31:0] bid_px;
    logic [31:0] ask_px;
    logic [63:0] event_time;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [4:0]  base_index;
    logic [4:0]  pivot_index;
    logic [4:0]  quote_index;
    logic [31:0] path_rate;
    logic [31:0] opportunity_id;
    logic [4:0]  found_count;
    logic [63:0] stamp;
    logic        last;

    arb_scoreboard board;
    longint       cycles;
    bit           hold_off;

    triangular_arbitrage_detector dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .base_code(base_code), .quote_code(quote_code),
        .bid_px(bid_px), .ask_px(ask_px), .event_time(event_time),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .base_index(base_index), .pivot_index(pivot_index),
        .quote_index(quote_index), .path_rate(path_rate),
        .opportunity_id(opportunity_id), .found_count(found_count),
        .stamp(stamp), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [23:0] pick_code(int bad_pct);
        logic [23:0] c;
        if ($urandom_range(0, 99) < bad_pct)
        begin
            c = 24'($urandom);
            if ($urandom_range(0, 1))
                c = CODE_LIST[$urandom_range(0, CODE_COUNT - 1)] ^ (24'd1 << $urandom_range(0, 23));
            return c;
        end
        return CODE_LIST[$urandom_range(0, CURRENCY_COUNT - 1)];
    endfunction

    // prices near 1.0 in 1e-5 units so triangles land close to the threshold
    function automatic logic [31:0] near_price(logic [31:0] center);
        return center + 32'($urandom_range(0, 400)) - 32'd200;
    endfunction

    task automatic send_tick(logic [23:0] bc, logic [23:0] qc, logic [31:0] bid,
                             logic [31:0] ask, logic [63:0] ts);
        in_valid   <= 1'b1;
        base_code  <= bc;
        quote_code <= qc;
        bid_px     <= bid;
        ask_px     <= ask;
        event_time <= ts;
        do @(posedge clk); while (in_stall);
        board.note_tick(bc, qc, bid, ask, ts);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_threshold(logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.threshold = v;
    endtask

    task automatic random_tick();
        logic [23:0] bc;
        logic [23:0] qc;
        logic [31:0] bid;
        logic [31:0] ask;
        int r;
        bc = pick_code(8);
        qc = pick_code(8);
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            bid = near_price(32'd100000);
            ask = near_price(32'd100000);
        end
        else if (r < 85)
        begin
            bid = $urandom;
            ask = $urandom;
        end
        else if (r < 92)
        begin
            bid = $urandom_range(0, 2);
            ask = $urandom_range(0, 2);
        end
        else
        begin
            bid = $urandom_range(1000, 10000000);
            ask = bid + $urandom_range(0, 1000);
        end
        send_tick(bc, qc, bid, ask, {$urandom, $urandom});
        idle_gap(gap_len());
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(0, 99) < 25);
    end

    always @(posedge clk)
    begin
        finding_t f;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            f.kind = kind;
            f.base_index = base_index;
            f.pivot_index = pivot_index;
            f.quote_index = quote_index;
            f.path_rate = path_rate;
            f.opportunity_id = opportunity_id;
            f.found_count = found_count;
            f.stamp = stamp;
            f.last = last;
            board.check_finding(f);
        end
    end

    always @(posedge clk)
    begin
        if (cycles > 64'd2000000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        board = new();
        hold_off = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 32'd0;
        in_valid = 1'b0;
        base_code = 24'd0;
        quote_code = 24'd0;
        bid_px = 32'd0;
        ask_px = 32'd0;
        event_time = 64'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rejects, extremes, then build a full triangle
        send_tick(24'h000000, CODE_LIST[0], 32'd100000, 32'd100000, 64'd0);
        send_tick(CODE_LIST[1], 24'hFFFFFF, 32'd100000, 32'd100000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_tick(CODE_LIST[2], CODE_LIST[2], 32'd100000, 32'd100000, 64'd3);
        send_tick(CODE_LIST[0], CODE_LIST[1], 32'd0, 32'd0, 64'd4);
        send_tick(CODE_LIST[0], CODE_LIST[1], 32'd0, 32'd1, 64'd5);
        send_tick(CODE_LIST[0], CODE_LIST[1], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd6);
        send_tick(CODE_LIST[0], CODE_LIST[1], 32'd0, 32'd2, 64'd7);
        for (int i = 1; i < CURRENCY_COUNT; i++)
            send_tick(CODE_LIST[0], CODE_LIST[i], 32'd100000, 32'd100100, 64'(10 + i));
        for (int i = 2; i < CURRENCY_COUNT; i++)
            send_tick(CODE_LIST[1], CODE_LIST[i], 32'd99000, 32'd99000, 64'(20 + i));
        drain();

        write_threshold(32'd0);
        send_tick(CODE_LIST[7], CODE_LIST[0], 32'd100000, 32'd100000, 64'd40);
        send_tick(CODE_LIST[1], CODE_LIST[0], 32'd90000, 32'd90000, 64'd41);
        drain();
        write_threshold(32'hFFFF_FFFF);
        send_tick(CODE_LIST[1], CODE_LIST[0], 32'd90000, 32'd90000, 64'd42);
        drain();
        write_threshold(THRESHOLD_RESET);

        // long receiver hold-off while ticks keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                repeat (12) random_tick();
            end
        join

        for (int n = 0; n < 240; n++)
        begin
            random_tick();
            if (n % 60 == 59)
            begin
                drain();
                case ((n / 60) % 4)
                    0: write_threshold(32'h0100_0000 - 32'($urandom_range(0, 20000)));
                    1: write_threshold($urandom);
                    2: write_threshold(32'h0100_0000 + 32'($urandom_range(0, 20000)));
                    default: write_threshold(32'h00FF_0000);
                endcase
            end
        end
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
